// ===== src/tx_mailbox_timeout_tracker_macros.svh =====
// assertion helpers for the mailbox timeout tracker
`ifndef TX_MAILBOX_TIMEOUT_TRACKER_MACROS_SVH
`define TX_MAILBOX_TIMEOUT_TRACKER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TMT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tmt_pkg.sv =====
`default_nettype none
package tmt_pkg;

  // field widths
  localparam int OPCODE_W   = 2;
  localparam int MBOX_W     = 8;
  localparam int DONE_W     = 16;
  localparam int EVENT_W    = 3;
  localparam int TOTAL_W    = 5;
  localparam int WAIT_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_INIT   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SUBMIT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd2;

  // event codes
  localparam logic [EVENT_W-1:0] EV_ACCEPTED = 3'd0;
  localparam logic [EVENT_W-1:0] EV_REJECTED = 3'd1;
  localparam logic [EVENT_W-1:0] EV_CONFIRM  = 3'd2;
  localparam logic [EVENT_W-1:0] EV_TIMEOUT  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_SCANDONE = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STARTED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd1;

  localparam logic [WAIT_W-1:0] LIMIT_RESET = 8'd100;
  localparam logic [WAIT_W-1:0] WAIT_MAX    = 8'hFF;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 5'd31;

  typedef struct packed {
    logic              started;
    logic [WAIT_W-1:0] limit;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== src/tmt_wait_ram.sv =====
`default_nettype none
module tmt_wait_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [ADDR_W-1:0]          wr_addr,
  input  wire logic [tmt_pkg::WAIT_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0]          rd_addr,
  output logic      [tmt_pkg::WAIT_W-1:0] rd_data
);
  import tmt_pkg::*;

  logic [WAIT_W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== src/tmt_cfg_regs.sv =====
`default_nettype none
module tmt_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [tmt_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [tmt_pkg::CFG_DATA_W-1:0] wr_data,
  output tmt_pkg::cfg_t                       cfg
);
  import tmt_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register decode, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_STARTED: cfg_nxt.started = wr_data[0];
        CFG_LIMIT:   cfg_nxt.limit   = wr_data[WAIT_W-1:0];
        default:     cfg_nxt         = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.started <= 1'b0;
      cfg_r.limit   <= LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== src/tx_mailbox_timeout_tracker.sv =====
`default_nettype none
`include "tx_mailbox_timeout_tracker_macros.svh"
// Transmit mailbox timeout tracker.
// Commands enter on start with in_opcode, in_mailbox, in_pointer_valid and
// in_done_mask; a beat is taken when start is high and busy is low.
// Results leave on out_valid for one cycle each, out_last marks the final
// result of a command. The receiver cannot stall; results are never held.
// Init and submit give one result in the cycle after the beat and leave
// busy low, so a new command may follow at once. A tick while stopped gives
// only the scan-done result, also in the cycle after the beat.
// A tick while started walks the wait-count memory one mailbox per cycle
// (one read port with a registered read, evaluation in the eval registers
// behind the read): busy stays high through the scan, flush and done states,
// events come out during the walk and the scan-done result comes last.
// Registers are written on cfg_valid; cfg_ready is always high. Write them
// only while the block is quiet.
// Reset clears pending marks, the pending count and the initialized flag;
// the wait counts are only read behind a pending mark and need no clearing.
module tx_mailbox_timeout_tracker #(
  parameter int MAILBOXES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [tmt_pkg::OPCODE_W-1:0]   in_opcode,
  input  wire logic [tmt_pkg::MBOX_W-1:0]     in_mailbox,
  input  wire logic                           in_pointer_valid,
  input  wire logic [tmt_pkg::DONE_W-1:0]     in_done_mask,
  output logic                                out_valid,
  output logic      [tmt_pkg::EVENT_W-1:0]    out_event_res,
  output logic      [tmt_pkg::MBOX_W-1:0]     out_event_mailbox,
  output logic      [tmt_pkg::TOTAL_W-1:0]    out_pending_total,
  output logic                                out_last,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tmt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tmt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tmt_pkg::*;

  localparam int IDX_W = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;
  localparam int CNT_W = $clog2(MAILBOXES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAILBOXES - 1);

  cfg_t cfg;

  state_t state_r, state_nxt;
  logic [MAILBOXES-1:0] mark_r, mark_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 init_r, init_nxt;
  logic [IDX_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic                 eval_vld_r, eval_vld_nxt;
  logic [IDX_W-1:0]     eval_idx_r, eval_idx_nxt;
  logic [DONE_W-1:0]    done_r, done_nxt;

  logic                 out_valid_r;
  logic [EVENT_W-1:0]   out_res_r;
  logic [MBOX_W-1:0]    out_mbox_r;
  logic [TOTAL_W-1:0]   out_total_r;
  logic                 out_last_r;

  logic                 ev_vld;
  logic [EVENT_W-1:0]   ev_res;
  logic [MBOX_W-1:0]    ev_mbox;
  logic                 ev_last;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WAIT_W-1:0]    ram_wdata;
  logic [WAIT_W-1:0]    ram_rdata;

  logic                 accept;
  logic [MBOX_W-1:0]    eval_ext;
  logic                 eval_done;
  logic [WAIT_W-1:0]    wait_inc;

  logic                 in_walk;
  logic                 cmd_beat;
  logic                 done_beat;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  tmt_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tmt_wait_ram #(
    .DEPTH  (MAILBOXES),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (scan_idx_r),
    .rd_data (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_opcode == OP_TICK && cfg.started) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // evaluation helpers for the entry whose count is on the read port
  assign eval_ext  = MBOX_W'(eval_idx_r);
  assign eval_done = (eval_ext < MBOX_W'(DONE_W)) && done_r[eval_ext[3:0]];
  assign wait_inc  = (ram_rdata == WAIT_MAX) ? WAIT_MAX : ram_rdata + 8'd1;

  // datapath and events
  always_comb begin
    mark_nxt     = mark_r;
    cnt_nxt      = cnt_r;
    init_nxt     = init_r;
    scan_idx_nxt = scan_idx_r;
    eval_vld_nxt = 1'b0;
    eval_idx_nxt = scan_idx_r;
    done_nxt     = done_r;
    ram_we       = 1'b0;
    ram_waddr    = scan_idx_r;
    ram_wdata    = '0;
    ev_vld       = 1'b0;
    ev_res       = EV_ACCEPTED;
    ev_mbox      = '0;
    ev_last      = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ev_vld = 1'b1;
          case (in_opcode)
            OP_INIT: begin
              if (!in_pointer_valid) begin
                ev_res = EV_REJECTED;
              end else begin
                mark_nxt = '0;
                cnt_nxt  = '0;
                init_nxt = 1'b1;
              end
            end
            OP_SUBMIT: begin
              ev_mbox = in_mailbox;
              if (!init_r || !in_pointer_valid) begin
                ev_res = EV_REJECTED;
              end else if (in_mailbox < MBOX_W'(MAILBOXES)) begin
                if (!mark_r[in_mailbox[IDX_W-1:0]]) begin
                  mark_nxt[in_mailbox[IDX_W-1:0]] = 1'b1;
                  cnt_nxt = cnt_r + 1'b1;
                end
                ram_we    = 1'b1;
                ram_waddr = in_mailbox[IDX_W-1:0];
                ram_wdata = '0;
              end
            end
            OP_TICK: begin
              done_nxt = in_done_mask;
              if (cfg.started) begin
                ev_vld       = 1'b0;
                scan_idx_nxt = '0;
              end else begin
                ev_res = EV_SCANDONE;
              end
            end
            default: ev_res = EV_REJECTED;
          endcase
        end
      end
      ST_SCAN: begin
        eval_vld_nxt = 1'b1;
        eval_idx_nxt = scan_idx_r;
        if (scan_idx_r != LAST_IDX) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        ev_vld = 1'b1;
        ev_res = EV_SCANDONE;
      end
      default: begin
      end
    endcase

    // one pending mailbox per cycle: confirm, count, or time out
    if (eval_vld_r && mark_r[eval_idx_r]) begin
      ev_mbox = eval_ext;
      ev_last = 1'b0;
      if (eval_done) begin
        mark_nxt[eval_idx_r] = 1'b0;
        cnt_nxt = cnt_r - 1'b1;
        ev_vld  = 1'b1;
        ev_res  = EV_CONFIRM;
      end else if (wait_inc >= cfg.limit) begin
        mark_nxt[eval_idx_r] = 1'b0;
        cnt_nxt = cnt_r - 1'b1;
        ev_vld  = 1'b1;
        ev_res  = EV_TIMEOUT;
      end else begin
        ram_we    = 1'b1;
        ram_waddr = eval_idx_r;
        ram_wdata = wait_inc;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mark_r      <= '0;
      cnt_r       <= '0;
      init_r      <= 1'b0;
      scan_idx_r  <= '0;
      eval_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mark_r      <= mark_nxt;
      cnt_r       <= cnt_nxt;
      init_r      <= init_nxt;
      scan_idx_r  <= scan_idx_nxt;
      eval_vld_r  <= eval_vld_nxt;
      out_valid_r <= ev_vld;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    eval_idx_r  <= eval_idx_nxt;
    done_r      <= done_nxt;
    out_res_r   <= ev_res;
    out_mbox_r  <= ev_mbox;
    out_last_r  <= ev_last;
    out_total_r <= (32'(cnt_nxt) > 32'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(cnt_nxt);
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = out_res_r;
  assign out_event_mailbox = out_mbox_r;
  assign out_pending_total = out_total_r;
  assign out_last          = out_last_r;

  // terms for the checks
  assign in_walk   = (state_r == ST_SCAN) || (state_r == ST_FLUSH);
  assign cmd_beat  = accept && (in_opcode != OP_TICK);
  assign done_beat = out_valid_r && out_last_r && (out_res_r == EV_SCANDONE);

  // checks
  `TMT_ASSERT_IMPL(a_count_matches_marks, 1'b1, 32'(cnt_r) == $countones(mark_r), "count mismatch")
  `TMT_ASSERT_IMPL(a_eval_in_scan, eval_vld_r, in_walk, "evaluation outside a scan")
  `TMT_ASSERT_NEXT(a_done_emits_last, state_r == ST_DONE, done_beat, "scan done missing")
  `TMT_ASSERT_NEXT(a_single_result, cmd_beat, out_valid_r && out_last_r && !busy, "no result")

endmodule
`default_nettype wire

// ===== tb/tb_tx_mailbox_timeout_tracker.sv =====
`timescale 1ns / 1ps

module tb_tx_mailbox_timeout_tracker;
  import tmt_pkg::*;

  localparam int NUM_MBX = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  // one result beat as seen on the out_ ports
  typedef struct packed {
    logic [EVENT_W-1:0] res;
    logic [MBOX_W-1:0]  mbx;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } mbx_event_t;

  // predicts the event stream of the tracker and checks it beat by beat
  class tracker_scoreboard;
    logic              cfg_started;
    logic [WAIT_W-1:0] cfg_limit;
    bit                is_init;
    bit                marked[NUM_MBX];
    logic [WAIT_W-1:0] waited[NUM_MBX];
    int unsigned       marked_total;
    mbx_event_t        due_events[$];
    int unsigned       errors;

    function new();
      cfg_started = 1'b0;
      cfg_limit = LIMIT_RESET;
      is_init = 1'b0;
      errors = 0;
      clear_marks();
    endfunction

    function void clear_marks();
      for (int i = 0; i < NUM_MBX; i++) begin
        marked[i] = 1'b0;
        waited[i] = '0;
      end
      marked_total = 0;
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function int unsigned due_count();
      return due_events.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_STARTED) begin
        cfg_started = data[0];
      end else if (idx == CFG_LIMIT) begin
        cfg_limit = data;
      end
    endfunction

    // queue one event; the total is taken after the state change
    function void push(logic [EVENT_W-1:0] res, logic [MBOX_W-1:0] mbx, logic fin);
      mbx_event_t ev;
      ev.res = res;
      ev.mbx = mbx;
      ev.total = (marked_total > TOTAL_MAX) ? TOTAL_MAX : marked_total[TOTAL_W-1:0];
      ev.last = fin;
      due_events.push_back(ev);
    endfunction

    // work out every event caused by one accepted command beat
    function void predict_events(logic [OPCODE_W-1:0] op, logic [MBOX_W-1:0] mbx,
                                 logic ptr_ok, logic [DONE_W-1:0] done);
      case (op)
        OP_INIT: begin
          if (!ptr_ok) begin
            push(EV_REJECTED, '0, 1'b1);
          end else begin
            clear_marks();
            is_init = 1'b1;
            push(EV_ACCEPTED, '0, 1'b1);
          end
        end
        OP_SUBMIT: begin
          if (!is_init || !ptr_ok) begin
            push(EV_REJECTED, mbx, 1'b1);
          end else begin
            // handles past the table are accepted but not tracked
            if (mbx < NUM_MBX) begin
              if (!marked[mbx]) begin
                marked[mbx] = 1'b1;
                marked_total++;
              end
              waited[mbx] = '0;
            end
            push(EV_ACCEPTED, mbx, 1'b1);
          end
        end
        OP_TICK: begin
          if (cfg_started) begin
            for (int i = 0; i < NUM_MBX; i++) begin
              if (marked[i]) begin
                if (i < DONE_W && done[i]) begin
                  marked[i] = 1'b0;
                  waited[i] = '0;
                  marked_total--;
                  push(EV_CONFIRM, MBOX_W'(i), 1'b0);
                end else begin
                  if (waited[i] != WAIT_MAX) waited[i]++;
                  if (waited[i] >= cfg_limit) begin
                    marked[i] = 1'b0;
                    waited[i] = '0;
                    marked_total--;
                    push(EV_TIMEOUT, MBOX_W'(i), 1'b0);
                  end
                end
              end
            end
          end
          push(EV_SCANDONE, '0, 1'b1);
        end
        default: begin
          push(EV_REJECTED, '0, 1'b1);
        end
      endcase
    endfunction

    task check_result(mbx_event_t got);
      mbx_event_t want;
      if (due_events.size() == 0) begin
        report($sformatf("unexpected result res=%0d mbx=%0d total=%0d last=%0d",
                         got.res, got.mbx, got.total, got.last));
        return;
      end
      want = due_events.pop_front();
      if (got.res !== want.res)
        report($sformatf("event_res got %0d want %0d", got.res, want.res));
      if (got.mbx !== want.mbx)
        report($sformatf("event_mailbox got %0d want %0d", got.mbx, want.mbx));
      if (got.total !== want.total)
        report($sformatf("pending_total got %0d want %0d", got.total, want.total));
      if (got.last !== want.last)
        report($sformatf("last got %0d want %0d", got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [OPCODE_W-1:0] in_opcode;
  logic [MBOX_W-1:0] in_mailbox;
  logic in_pointer_valid;
  logic [DONE_W-1:0] in_done_mask;
  logic out_valid;
  logic [EVENT_W-1:0] out_event_res;
  logic [MBOX_W-1:0] out_event_mailbox;
  logic [TOTAL_W-1:0] out_pending_total;
  logic out_last;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tracker_scoreboard sb;
  int unsigned cycle_count = 0;

  tx_mailbox_timeout_tracker #(.MAILBOXES(NUM_MBX)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_opcode(in_opcode),
    .in_mailbox(in_mailbox),
    .in_pointer_valid(in_pointer_valid),
    .in_done_mask(in_done_mask),
    .out_valid(out_valid),
    .out_event_res(out_event_res),
    .out_event_mailbox(out_event_mailbox),
    .out_pending_total(out_pending_total),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result monitor, one beat per strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result('{out_event_res, out_event_mailbox, out_pending_total, out_last});
    end
  end

  // present one command and hold it until the beat is taken
  task automatic issue(logic [OPCODE_W-1:0] op, logic [MBOX_W-1:0] mbx,
                       logic ptr_ok, logic [DONE_W-1:0] done);
    start <= 1'b1;
    in_opcode <= op;
    in_mailbox <= mbx;
    in_pointer_valid <= ptr_ok;
    in_done_mask <= done;
    do @(posedge clk); while (busy);
    sb.predict_events(op, mbx, ptr_ok, done);
  endtask

  task automatic pause(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off until every predicted event has come out
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.due_count() != 0 || busy);
  endtask

  // write both registers back to back, block must be quiet
  task automatic configure(logic started, logic [CFG_DATA_W-1:0] limit);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_STARTED;
    cfg_data <= {{(CFG_DATA_W-1){1'b0}}, started};
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(CFG_STARTED, {{(CFG_DATA_W-1){1'b0}}, started});
    cfg_index <= CFG_LIMIT;
    cfg_data <= limit;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(CFG_LIMIT, limit);
    cfg_valid <= 1'b0;
  endtask

  // done masks: none, one bit, sparse or dense
  function automatic logic [DONE_W-1:0] tick_mask();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 16'h1 << $urandom_range(0, DONE_W - 1);
      2: return DONE_W'($urandom & $urandom & $urandom);
      default: return DONE_W'($urandom);
    endcase
  endfunction

  task automatic issue_random();
    int unsigned pick;
    logic [MBOX_W-1:0] any_mbx;
    logic [DONE_W-1:0] any_done;
    pick = $urandom_range(0, 99);
    any_mbx = MBOX_W'($urandom_range(0, 255));
    any_done = DONE_W'($urandom);
    if (pick < 45) begin
      issue(OP_SUBMIT, MBOX_W'($urandom_range(0, NUM_MBX - 1)), 1'b1, any_done);
    end else if (pick < 72) begin
      issue(OP_TICK, any_mbx, 1'($urandom_range(0, 1)), tick_mask());
    end else if (pick < 80) begin
      issue(OP_SUBMIT, any_mbx, 1'($urandom_range(0, 1)), any_done);
    end else if (pick < 85) begin
      issue(OP_SUBMIT, any_mbx, 1'b0, any_done);
    end else if (pick < 88) begin
      issue(OP_INIT, any_mbx, 1'b1, any_done);
    end else if (pick < 94) begin
      issue(OP_INIT, any_mbx, 1'b0, any_done);
    end else begin
      issue(OP_UNUSED, any_mbx, 1'($urandom_range(0, 1)), any_done);
    end
  endtask

  // one setting: fill the table when started, then bursts of mixed commands
  task automatic random_phase(logic started, logic [CFG_DATA_W-1:0] limit, int unsigned count);
    int unsigned sent;
    int unsigned burst;
    int unsigned offset;
    drain();
    configure(started, limit);
    sent = 0;
    if (started) begin
      issue(OP_INIT, MBOX_W'($urandom_range(0, 255)), 1'b1, DONE_W'($urandom));
      offset = $urandom_range(0, NUM_MBX - 1);
      for (int k = 0; k < NUM_MBX; k++) begin
        issue(OP_SUBMIT, MBOX_W'((k + offset) % NUM_MBX), 1'b1, DONE_W'($urandom));
      end
      repeat (3) issue(OP_TICK, MBOX_W'($urandom_range(0, 255)), 1'b1, tick_mask());
      sent = NUM_MBX + 4;
    end
    while (sent < count) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      repeat (burst) begin
        issue_random();
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        drain();
      end else begin
        pause($urandom_range(1, 8));
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n <= 1'b0;
    start <= 1'b0;
    in_opcode <= OP_INIT;
    in_mailbox <= '0;
    in_pointer_valid <= 1'b0;
    in_done_mask <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_STARTED;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stopped controller, default limit: rejects and untracked handles
    issue(OP_SUBMIT, 8'd3, 1'b1, 16'h0000);
    issue(OP_INIT, 8'd0, 1'b0, 16'h0000);
    issue(OP_TICK, 8'd0, 1'b1, 16'hFFFF);
    issue(OP_UNUSED, 8'hFF, 1'b1, 16'hFFFF);
    issue(OP_INIT, 8'hA5, 1'b1, 16'h5A5A);
    issue(OP_SUBMIT, 8'd0, 1'b0, 16'h0000);
    issue(OP_SUBMIT, 8'd0, 1'b1, 16'h0000);
    issue(OP_SUBMIT, 8'd15, 1'b1, 16'h0000);
    issue(OP_SUBMIT, 8'd16, 1'b1, 16'h0000);
    issue(OP_SUBMIT, 8'd255, 1'b1, 16'hFFFF);
    issue(OP_SUBMIT, 8'd0, 1'b1, 16'h0000);
    issue(OP_TICK, 8'd0, 1'b1, 16'hFFFF);

    // started: confirm, restart by resubmit, then timeout
    drain();
    configure(1'b1, 8'd2);
    issue(OP_TICK, 8'd0, 1'b1, 16'h8000);
    issue(OP_SUBMIT, 8'd0, 1'b1, 16'h0000);
    issue(OP_TICK, 8'd0, 1'b1, 16'hFFFE);
    issue(OP_TICK, 8'd0, 1'b1, 16'h7FFE);

    // limit lowered below a running counter
    drain();
    configure(1'b1, LIMIT_RESET);
    issue(OP_SUBMIT, 8'd4, 1'b1, 16'h0000);
    issue(OP_TICK, 8'd0, 1'b1, 16'h0000);
    issue(OP_TICK, 8'd0, 1'b1, 16'h0000);
    drain();
    configure(1'b1, 8'd1);
    issue(OP_TICK, 8'd0, 1'b1, 16'h0000);

    // zero limit drops on the first not-done tick
    drain();
    configure(1'b1, 8'd0);
    issue(OP_SUBMIT, 8'd7, 1'b1, 16'h0000);
    issue(OP_SUBMIT, 8'd9, 1'b1, 16'h0000);
    issue(OP_TICK, 8'd0, 1'b1, 16'h0200);
    issue(OP_TICK, 8'd0, 1'b1, 16'hFFFF);

    // random phases over several settings
    random_phase(1'b1, 8'd1, 55);
    random_phase(1'b1, 8'd3, 55);
    random_phase(1'b1, 8'd255, 55);
    random_phase(1'b0, LIMIT_RESET, 55);
    random_phase(1'b1, 8'd2, 55);
    random_phase(1'b1, 8'd0, 55);
    random_phase(1'b1, CFG_DATA_W'($urandom_range(1, 8)), 55);

    drain();
    repeat (NUM_MBX + 4) @(posedge clk);
    if (sb.due_count() != 0) begin
      sb.report($sformatf("%0d predicted events never came out", sb.due_count()));
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
